### hw/rtl/kfsd_pkg.sv
package kfsd_pkg;

	localparam int POOL_DEPTH_DEF = 16;
	localparam int SIG_W          = 6;
	localparam int WORD_W         = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_FINISH
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

### hw/rtl/kfsd_ctrl.sv
module kfsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output kfsd_pkg::cmd_t cmd
);
	import kfsd_pkg::*;

	fsm_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				// hold the item until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_commit_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result beat");

	a_capture_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == FSM_FINISH))
		else $error("captured beat not followed by finish");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.commit)
		else $error("commit over a stalled result");

endmodule

### hw/rtl/kfsd_dp.sv
module kfsd_dp #(
	parameter int POOL_DEPTH = kfsd_pkg::POOL_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kfsd_pkg::cmd_t             cmd,
	input  logic                       kind,
	input  logic [kfsd_pkg::SIG_W-1:0]  signal_number,
	input  logic [kfsd_pkg::WORD_W-1:0] info_word,
	output logic [1:0]                 status,
	output logic                       more_pending,
	output logic [kfsd_pkg::WORD_W-1:0] info_out
);
	import kfsd_pkg::*;

	localparam int OCC_W = $clog2(POOL_DEPTH + 1);

	logic [SIG_W-1:0]  sig_q [POOL_DEPTH];
	logic [WORD_W-1:0] pay_q [POOL_DEPTH];
	logic [OCC_W-1:0]  occ_q;

	kind_t             kind_s1;
	logic [SIG_W-1:0]  sig_s1;
	logic [WORD_W-1:0] word_s1;
	logic [POOL_DEPTH-1:0] hit_s1;
	logic              more_s1;

	logic [POOL_DEPTH-1:0] match;
	logic [POOL_DEPTH-1:0] first;
	logic [POOL_DEPTH-1:0] shift_en;
	logic [WORD_W-1:0]     sel_pay;
	logic                  found;
	logic                  full;

	status_t           status_q;
	logic              more_q;
	logic [WORD_W-1:0] info_q;

	// parallel compare against live slots, keep the oldest hit
	always_comb begin
		for (int i = 0; i < POOL_DEPTH; i++) begin
			match[i] = (OCC_W'(i) < occ_q) && (sig_q[i] == signal_number);
		end
		first = match & (~match + 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1 <= kind_t'(kind);
			sig_s1  <= signal_number;
			word_s1 <= info_word;
			hit_s1  <= first;
			more_s1 <= |(match & ~first);
		end
	end

	assign found    = |hit_s1;
	assign full     = (occ_q == OCC_W'(POOL_DEPTH));
	assign shift_en = ~(hit_s1 - 1'b1);

	always_comb begin
		sel_pay = '0;
		for (int i = 0; i < POOL_DEPTH; i++) begin
			sel_pay = sel_pay | ({WORD_W{hit_s1[i]}} & pay_q[i]);
		end
	end

	// append at tail, or compact everything above the removed slot
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < POOL_DEPTH; i++) begin
				if (kind_s1 == KIND_ENQ) begin
					if (!full && (OCC_W'(i) == occ_q)) begin
						sig_q[i] <= sig_s1;
						pay_q[i] <= word_s1;
					end
				end else if (found && shift_en[i] && (i + 1 < POOL_DEPTH)) begin
					sig_q[i] <= sig_q[(i + 1) % POOL_DEPTH];
					pay_q[i] <= pay_q[(i + 1) % POOL_DEPTH];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.commit) begin
			if (kind_s1 == KIND_ENQ) begin
				if (!full) begin
					occ_q <= occ_q + 1'b1;
				end
			end else if (found) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (kind_s1 == KIND_ENQ) begin
				status_q <= full ? ST_FULL : ST_OK;
				more_q   <= 1'b0;
				info_q   <= '0;
			end else begin
				status_q <= found ? ST_OK : ST_NOT_FOUND;
				more_q   <= found & more_s1;
				info_q   <= found ? sel_pay : '0;
			end
		end
	end

	assign status       = status_q;
	assign more_pending = more_q;
	assign info_out     = info_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(POOL_DEPTH))
		else $error("occupancy beyond pool depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> $onehot0(hit_s1))
		else $error("more than one slot selected");

	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && kind_s1 == KIND_DEQ && found) |=> occ_q == $past(occ_q) - 1'b1)
		else $error("dequeue did not drop occupancy");

endmodule

### hw/rtl/keyed_fifo_selective_dequeue_top.sv
// Keyed FIFO with selective dequeue.
// Input channel (in_valid / in_stall) carries one beat per operation:
//   kind 0 appends {signal_number, info_word} at the tail of the queue,
//   kind 1 removes the oldest queued record whose number equals signal_number.
// Output channel (out_valid / out_stall) returns exactly one beat per input
// beat, in order: status (0 ok, 1 full, 2 not found), more_pending and info_out.
// The accept cycle runs the parallel compare of all pool slots and latches
// the oldest hit; the commit then shifts the later records down one slot
// (or writes the tail) and loads the output register.
// The result is visible the cycle after that commit, and a new beat is
// taken only once the previous one has committed.
// A finished result waits in the output register; the next beat is still
// accepted, and its commit holds only while that older result is stalled.
// Reset empties the queue at once; no clearing pass is needed.
module keyed_fifo_selective_dequeue_top #(
	parameter int POOL_DEPTH = kfsd_pkg::POOL_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [kfsd_pkg::SIG_W-1:0]  signal_number,
	input  logic [kfsd_pkg::WORD_W-1:0] info_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic                        more_pending,
	output logic [kfsd_pkg::WORD_W-1:0] info_out
);
	import kfsd_pkg::*;

	cmd_t cmd;

	kfsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	kfsd_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.signal_number (signal_number),
		.info_word     (info_word),
		.status        (status),
		.more_pending  (more_pending),
		.info_out      (info_out)
	);

endmodule

### test/tb_keyed_fifo_selective_dequeue_top.sv
module tb_keyed_fifo_selective_dequeue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kfsd_pkg::*;

	localparam int DEPTH          = POOL_DEPTH_DEF;
	localparam int RANDOM_OPS     = 1680;
	localparam int BIAS_SPAN      = 40;
	localparam int DRAIN_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [1:0] STALL_NONE     = 2'd0;
	localparam logic [1:0] STALL_COIN     = 2'd1;
	localparam logic [1:0] STALL_HEAVY    = 2'd2;
	localparam logic [1:0] STALL_PERIODIC = 2'd3;

	typedef struct {
		kind_t              kind;
		logic [SIG_W-1:0]   sig;
		logic [WORD_W-1:0]  word;
	} sig_op_t;

	typedef struct {
		status_t            status;
		logic               more;
		logic [WORD_W-1:0]  info;
	} sig_reply_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic                kind          = 1'b0;
	logic [SIG_W-1:0]    signal_number = '0;
	logic [WORD_W-1:0]   info_word     = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic [1:0]          status;
	logic                more_pending;
	logic [WORD_W-1:0]   info_out;

	// queue contents as the block should hold them, oldest in slot 0
	logic [SIG_W-1:0]    queued_sig  [DEPTH];
	logic [WORD_W-1:0]   queued_word [DEPTH];
	int                  queued_count = 0;

	sig_op_t             pending_ops[$];
	sig_reply_t          expected_replies[$];
	sig_op_t             next_op;
	sig_reply_t          want_reply;

	logic                in_taken     = 1'b0;
	int                  beats_in     = 0;
	int                  beats_out    = 0;
	int                  mismatches   = 0;
	int                  idle_cycles  = 0;
	int                  burst_left   = 0;
	int                  gap_left     = 0;
	int                  hold_left    = 0;
	int                  holds_done   = 0;
	logic [7:0]          stall_tick   = '0;

	keyed_fifo_selective_dequeue_top #(
		.POOL_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.signal_number(signal_number),
		.info_word    (info_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.more_pending (more_pending),
		.info_out     (info_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one operation to the expected queue and return the reply it earns.
	function automatic sig_reply_t dequeue_or_append(kind_t k, logic [SIG_W-1:0] s,
			logic [WORD_W-1:0] w);
		sig_reply_t r;
		bit         hit;
		int         pos;
		r.status = ST_OK;
		r.more   = 1'b0;
		r.info   = '0;
		hit      = 1'b0;
		pos      = 0;
		if (k == KIND_ENQ) begin
			if (queued_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				queued_sig[queued_count]  = s;
				queued_word[queued_count] = w;
				queued_count++;
			end
		end else begin
			for (int i = 0; i < queued_count; i++) begin
				if (queued_sig[i] == s) begin
					if (hit)
						r.more = 1'b1;
					else begin
						hit = 1'b1;
						pos = i;
					end
				end
			end
			if (!hit) begin
				r.status = ST_NOT_FOUND;
				r.more   = 1'b0;
			end else begin
				r.info = queued_word[pos];
				// close the gap, later records keep their order
				for (int i = pos; i < queued_count - 1; i++) begin
					queued_sig[i]  = queued_sig[i + 1];
					queued_word[i] = queued_word[i + 1];
				end
				queued_count--;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
			logic [WORD_W-1:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h", beats_out, what, got, want);
		mismatches++;
	endtask

	task automatic push_op(kind_t k, logic [SIG_W-1:0] s, logic [WORD_W-1:0] w);
		sig_op_t op;
		op.kind = k;
		op.sig  = s;
		op.word = w;
		pending_ops.push_back(op);
	endtask

	// driver: present a new beat once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				next_op = pending_ops.pop_front();
				kind          <= next_op.kind;
				signal_number <= next_op.sig;
				info_word     <= next_op.word;
				in_valid      <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall: long hold-offs at two points, otherwise a rotating pattern
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if ((holds_done == 0 && beats_in >= 400) ||
				(holds_done == 1 && beats_in >= 1300)) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			stall_tick++;
			case (stall_tick[7:6])
				STALL_NONE:     out_stall <= 1'b0;
				STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: out_stall <= (stall_tick[1:0] == 2'd0);
			endcase
		end
	end

	// monitor: predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_replies.push_back(dequeue_or_append(kind_t'(kind), signal_number,
				info_word));
			beats_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected result, status", WORD_W'(status), '0);
			end else begin
				want_reply = expected_replies.pop_front();
				if (status !== want_reply.status)
					report_mismatch("status", WORD_W'(status), WORD_W'(want_reply.status));
				if (more_pending !== want_reply.more)
					report_mismatch("more_pending", WORD_W'(more_pending),
						WORD_W'(want_reply.more));
				if (info_out !== want_reply.info)
					report_mismatch("info_out", info_out, want_reply.info);
			end
			beats_out++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] w;
		logic [SIG_W-1:0]  s;
		kind_t             k;
		int                enq_pct;
		int                total_ops;
		// dequeue from an empty queue, overfill the pool, then drain by number
		push_op(KIND_DEQ, 6'd5, 32'hdead_beef);
		for (int i = 0; i <= DEPTH; i++) begin
			s = (i % 3 == 0) ? 6'd0 : ((i % 3 == 1) ? 6'd63 : 6'd9);
			push_op(KIND_ENQ, s, 32'h1000_0000 + 32'(i));
		end
		for (int i = 0; i <= DEPTH; i++) begin
			s = (i % 3 == 0) ? 6'd9 : ((i % 3 == 1) ? 6'd0 : 6'd63);
			push_op(KIND_DEQ, s, $urandom());
		end
		// alternate fill-heavy and drain-heavy stretches over a few busy numbers
		for (int i = 0; i < RANDOM_OPS; i++) begin
			enq_pct = ((i / BIAS_SPAN) % 2 == 0) ? 65 : 35;
			k = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
			if ($urandom_range(0, 7) == 0)
				s = SIG_W'($urandom_range(0, 63));
			else
				s = SIG_W'($urandom_range(1, 6));
			w = $urandom();
			push_op(k, s, w);
		end
		total_ops = pending_ops.size();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (beats_out >= total_ops);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && beats_in == total_ops && beats_out == total_ops &&
				expected_replies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/kfsd_pkg.sv
hw/rtl/kfsd_ctrl.sv
hw/rtl/kfsd_dp.sv
hw/rtl/keyed_fifo_selective_dequeue_top.sv
test/tb_keyed_fifo_selective_dequeue_top.sv
